[rtl/mmlb_pkg.sv]
// Shared types and constants for the multi-mode lamp blinker.
// No dependencies; imported by mmlb_core, multi_mode_lamp_blinker_top and the testbench.
package mmlb_pkg;

  // Configuration register map
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_COURTESY_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_CLOSE_TIME = 2'd1;

  // Pattern constants
  localparam logic [7:0] SLOW_DIV = 8'd3;
  localparam logic [7:0] RECOV_OFF_TICKS = 8'd3;
  localparam logic [7:0] RECOV_ON_TICKS = 8'd6;
  localparam logic [7:0] DPULSE_PERIOD = 8'd30;
  localparam logic [7:0] DPULSE_FIRST = 8'd0;
  localparam logic [7:0] DPULSE_SECOND = 8'd2;

  typedef enum logic [1:0] {
    LAMP_RAPID = 2'd0,
    LAMP_SLOW = 2'd1,
    LAMP_RECOVERY = 2'd2,
    LAMP_HOLD = 2'd3
  } lamp_mode_t;

  typedef enum logic [1:0] {
    IND_HOLD = 2'd0,
    IND_SLOW = 2'd1,
    IND_FAST = 2'd2,
    IND_DPULSE = 2'd3
  } ind_mode_t;

  // One tick as it comes in
  typedef struct packed {
    logic lamp_enable;
    lamp_mode_t lamp_mode;
    ind_mode_t indicator_mode;
    logic courtesy_start;
    logic auto_close_enable;
    logic mask_toggle_enable;
    logic preflash_count_enable;
  } item_t;

  // One result
  typedef struct packed {
    logic lamp_on;
    logic indicator_on;
    logic courtesy_on;
    logic auto_close_command;
    logic hmi_mask_phase;
    logic [7:0] preflash_ticks;
  } res_t;

  // Timer presets from the configuration registers
  typedef struct packed {
    logic [15:0] courtesy_time;
    logic [15:0] auto_close_time;
  } cfg_t;

endpackage

[rtl/mmlb_core.sv]
// Tick state machines of the lamp blinker: all per-tick state and its update.
// Depends on mmlb_pkg. State advances once per tick when adv is high.
module mmlb_core import mmlb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  logic        lamp_level_r, lamp_level_nxt;
  logic [7:0]  lamp_div_r, lamp_div_nxt;
  logic        ind_level_r, ind_level_nxt;
  logic [7:0]  ind_div_r, ind_div_nxt;
  logic        court_active_r, court_active_nxt;
  logic [15:0] court_count_r, court_count_nxt;
  logic [15:0] close_count_r, close_count_nxt;
  logic        close_cmd_r, close_cmd_nxt;
  logic        mask_phase_r, mask_phase_nxt;
  logic [7:0]  preflash_r, preflash_nxt;

  logic [7:0]  lamp_inc, ind_inc;
  logic [15:0] court_base, court_inc, close_inc;
  logic        court_on;

  assign lamp_inc = lamp_div_r + 8'd1;
  assign ind_inc = ind_div_r + 8'd1;

  // Flashing lamp
  always_comb begin
    lamp_level_nxt = lamp_level_r;
    lamp_div_nxt = lamp_div_r;
    if (item.lamp_enable) begin
      unique case (item.lamp_mode)
        LAMP_RAPID: lamp_level_nxt = ~lamp_level_r;
        LAMP_SLOW: begin
          if (lamp_inc == SLOW_DIV) begin
            lamp_div_nxt = '0;
            lamp_level_nxt = ~lamp_level_r;
          end else begin
            lamp_div_nxt = lamp_inc;
          end
        end
        LAMP_RECOVERY: begin
          lamp_div_nxt = lamp_inc;
          if (lamp_inc == RECOV_OFF_TICKS && !lamp_level_r) begin
            lamp_div_nxt = '0;
            lamp_level_nxt = 1'b1;
          end else if (lamp_inc == RECOV_ON_TICKS && lamp_level_r) begin
            lamp_div_nxt = '0;
            lamp_level_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Gate-open indicator
  always_comb begin
    ind_level_nxt = ind_level_r;
    ind_div_nxt = ind_div_r;
    unique case (item.indicator_mode)
      IND_SLOW: begin
        if (ind_inc == SLOW_DIV) begin
          ind_div_nxt = '0;
          ind_level_nxt = ~ind_level_r;
        end else begin
          ind_div_nxt = ind_inc;
        end
      end
      IND_FAST: ind_level_nxt = ~ind_level_r;
      IND_DPULSE: begin
        ind_div_nxt = (ind_inc == DPULSE_PERIOD) ? 8'd0 : ind_inc;
        ind_level_nxt = (ind_div_nxt == DPULSE_FIRST) || (ind_div_nxt == DPULSE_SECOND);
      end
      default: ;
    endcase
  end

  // Courtesy light: a start restarts the count before this tick counts
  assign court_on = item.courtesy_start | court_active_r;
  assign court_base = item.courtesy_start ? 16'd0 : court_count_r;
  assign court_inc = court_base + 16'd1;

  always_comb begin
    court_active_nxt = court_on;
    court_count_nxt = court_base;
    if (court_on) begin
      court_count_nxt = court_inc;
      if (court_inc == cfg.courtesy_time) court_active_nxt = 1'b0;
    end
  end

  // Auto-close timer, mask and pre-flash counter
  assign close_inc = close_count_r + 16'd1;

  always_comb begin
    if (item.auto_close_enable) begin
      close_count_nxt = close_inc;
      close_cmd_nxt = close_cmd_r | (close_inc == cfg.auto_close_time);
    end else begin
      close_count_nxt = '0;
      close_cmd_nxt = 1'b0;
    end
    mask_phase_nxt = mask_phase_r ^ item.mask_toggle_enable;
    preflash_nxt = item.preflash_count_enable ? preflash_r + 8'd1 : 8'd0;
  end

  // Advance all state on each processed tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lamp_level_r <= 1'b0;
      lamp_div_r <= '0;
      ind_level_r <= 1'b0;
      ind_div_r <= '0;
      court_active_r <= 1'b0;
      court_count_r <= '0;
      close_count_r <= '0;
      close_cmd_r <= 1'b0;
      mask_phase_r <= 1'b0;
      preflash_r <= '0;
    end else if (adv) begin
      lamp_level_r <= lamp_level_nxt;
      lamp_div_r <= lamp_div_nxt;
      ind_level_r <= ind_level_nxt;
      ind_div_r <= ind_div_nxt;
      court_active_r <= court_active_nxt;
      court_count_r <= court_count_nxt;
      close_count_r <= close_count_nxt;
      close_cmd_r <= close_cmd_nxt;
      mask_phase_r <= mask_phase_nxt;
      preflash_r <= preflash_nxt;
    end
  end

  // The state after a tick is the result of that tick
  assign res.lamp_on = lamp_level_r;
  assign res.indicator_on = ind_level_r;
  assign res.courtesy_on = court_active_r;
  assign res.auto_close_command = close_cmd_r;
  assign res.hmi_mask_phase = mask_phase_r;
  assign res.preflash_ticks = preflash_r;

  // Check state update against the tick that caused it
  property p_preflash_clear;
    @(posedge clk) disable iff (!rst_n)
      adv && !item.preflash_count_enable |=> preflash_r == 8'd0;
  endproperty
  a_preflash_clear: assert property (p_preflash_clear)
    else $error("pre-flash counter not cleared");

  property p_close_clear;
    @(posedge clk) disable iff (!rst_n)
      adv && !item.auto_close_enable |=> !close_cmd_r && close_count_r == 16'd0;
  endproperty
  a_close_clear: assert property (p_close_clear)
    else $error("auto-close not cleared");

  property p_court_start;
    @(posedge clk) disable iff (!rst_n)
      adv && item.courtesy_start |=> court_count_r == 16'd1;
  endproperty
  a_court_start: assert property (p_court_start)
    else $error("courtesy count not restarted");

  property p_hold;
    @(posedge clk) disable iff (!rst_n)
      !adv |=> $stable(lamp_div_r) && $stable(court_count_r) && $stable(close_count_r);
  endproperty
  a_hold: assert property (p_hold)
    else $error("state moved without a tick");

endmodule

[rtl/multi_mode_lamp_blinker_top.sv]
// Multi-mode lamp blinker top level: handshake stages and config registers.
// Depends on mmlb_pkg and mmlb_core.
//
// An accepted tick is held in the input register until the result slot is free or
// being taken; its result is then registered in the tick state and shown on out_*.
// Throughput: one tick per cycle while out_ready stays high; the input register feeds
// the tick logic, whose state registers double as the result register.
// Reset (rst_n low, synchronous) clears all tick state, both presets and valids.
module multi_mode_lamp_blinker_top import mmlb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_lamp_enable,
  input  logic [1:0]           in_lamp_mode,
  input  logic [1:0]           in_indicator_mode,
  input  logic                 in_courtesy_start,
  input  logic                 in_auto_close_enable,
  input  logic                 in_mask_toggle_enable,
  input  logic                 in_preflash_count_enable,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_lamp_on,
  output logic                 out_indicator_on,
  output logic                 out_courtesy_on,
  output logic                 out_auto_close_command,
  output logic                 out_hmi_mask_phase,
  output logic [7:0]           out_preflash_ticks
);

  cfg_t  cfg_r;
  item_t item_r;
  logic  item_valid_r;
  logic  out_valid_r;
  logic  adv;
  res_t  res;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COURTESY_TIME: cfg_r.courtesy_time <= cfg_wdata;
        CFG_AUTO_CLOSE_TIME: cfg_r.auto_close_time <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Process the held tick when the result slot is free or being taken
  assign adv = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !item_valid_r || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.lamp_enable <= in_lamp_enable;
      item_r.lamp_mode <= lamp_mode_t'(in_lamp_mode);
      item_r.indicator_mode <= ind_mode_t'(in_indicator_mode);
      item_r.courtesy_start <= in_courtesy_start;
      item_r.auto_close_enable <= in_auto_close_enable;
      item_r.mask_toggle_enable <= in_mask_toggle_enable;
      item_r.preflash_count_enable <= in_preflash_count_enable;
    end
  end

  // Result valid: set on a processed tick, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  mmlb_core u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .adv  (adv),
    .item (item_r),
    .cfg  (cfg_r),
    .res  (res)
  );

  assign out_valid = out_valid_r;
  assign out_lamp_on = res.lamp_on;
  assign out_indicator_on = res.indicator_on;
  assign out_courtesy_on = res.courtesy_on;
  assign out_auto_close_command = res.auto_close_command;
  assign out_hmi_mask_phase = res.hmi_mask_phase;
  assign out_preflash_ticks = res.preflash_ticks;

  // Pipeline control checks
  property p_adv_fills;
    @(posedge clk) disable iff (!rst_n) adv |=> out_valid_r;
  endproperty
  a_adv_fills: assert property (p_adv_fills)
    else $error("processed tick produced no result");

  property p_no_overwrite;
    @(posedge clk) disable iff (!rst_n) out_valid_r && !out_ready |-> !adv;
  endproperty
  a_no_overwrite: assert property (p_no_overwrite)
    else $error("stalled result overwritten");

  property p_stall_holds_item;
    @(posedge clk) disable iff (!rst_n)
      item_valid_r && !adv |=> item_valid_r && $stable(item_r);
  endproperty
  a_stall_holds_item: assert property (p_stall_holds_item)
    else $error("waiting tick lost");

endmodule

[tb/multi_mode_lamp_blinker_top_tb.sv]
// Self-checking testbench for multi_mode_lamp_blinker_top: random ticks under handshake
// pressure, checked against a cycle-free tick predictor kept in a scoreboard class.
// Depends on mmlb_pkg and the multi_mode_lamp_blinker_top RTL.
`timescale 1ns / 100ps

module multi_mode_lamp_blinker_top_tb import mmlb_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned MAX_REPORTS = 10;
  // Register indexes that map to no preset; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  // Mirror of the blinker state; predicts one result per accepted tick
  class blinker_scoreboard;
    logic [15:0] courtesy_preset;
    logic [15:0] close_preset;
    logic        lamp_lvl;
    logic [7:0]  lamp_div;
    logic        ind_lvl;
    logic [7:0]  ind_div;
    logic        courtesy_act;
    logic [15:0] courtesy_cnt;
    logic [15:0] close_cnt;
    logic        close_cmd;
    logic        mask;
    logic [7:0]  pf_cnt;
    res_t        due_outputs[$];
    int unsigned err_count;

    function new();
      courtesy_preset = '0;
      close_preset = '0;
      lamp_lvl = 1'b0;
      lamp_div = '0;
      ind_lvl = 1'b0;
      ind_div = '0;
      courtesy_act = 1'b0;
      courtesy_cnt = '0;
      close_cnt = '0;
      close_cmd = 1'b0;
      mask = 1'b0;
      pf_cnt = '0;
      err_count = 0;
    endfunction

    function void set_preset(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        CFG_COURTESY_TIME: courtesy_preset = val;
        CFG_AUTO_CLOSE_TIME: close_preset = val;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return due_outputs.size();
    endfunction

    // Advance every machine by one tick and queue the levels it leaves
    function void note_tick(item_t t);
      res_t r;
      if (t.mask_toggle_enable) mask = ~mask;
      pf_cnt = t.preflash_count_enable ? pf_cnt + 8'd1 : 8'd0;

      if (t.lamp_enable) begin
        case (t.lamp_mode)
          LAMP_RAPID: lamp_lvl = ~lamp_lvl;
          LAMP_SLOW: begin
            lamp_div = lamp_div + 8'd1;
            if (lamp_div == SLOW_DIV) begin
              lamp_div = '0;
              lamp_lvl = ~lamp_lvl;
            end
          end
          LAMP_RECOVERY: begin
            lamp_div = lamp_div + 8'd1;
            if (lamp_div == RECOV_OFF_TICKS && !lamp_lvl) begin
              lamp_div = '0;
              lamp_lvl = 1'b1;
            end
            if (lamp_div == RECOV_ON_TICKS && lamp_lvl) begin
              lamp_div = '0;
              lamp_lvl = 1'b0;
            end
          end
          default: ;
        endcase
      end

      if (t.courtesy_start) begin
        courtesy_act = 1'b1;
        courtesy_cnt = '0;
      end
      if (courtesy_act) begin
        courtesy_cnt = courtesy_cnt + 16'd1;
        if (courtesy_cnt == courtesy_preset) courtesy_act = 1'b0;
      end

      case (t.indicator_mode)
        IND_SLOW: begin
          ind_div = ind_div + 8'd1;
          if (ind_div == SLOW_DIV) begin
            ind_div = '0;
            ind_lvl = ~ind_lvl;
          end
        end
        IND_FAST: ind_lvl = ~ind_lvl;
        IND_DPULSE: begin
          ind_div = ind_div + 8'd1;
          if (ind_div == DPULSE_PERIOD) ind_div = '0;
          ind_lvl = (ind_div == DPULSE_FIRST) || (ind_div == DPULSE_SECOND);
        end
        default: ;
      endcase

      if (t.auto_close_enable) begin
        close_cnt = close_cnt + 16'd1;
        if (close_cnt == close_preset) close_cmd = 1'b1;
      end else begin
        close_cnt = '0;
        close_cmd = 1'b0;
      end

      r.lamp_on = lamp_lvl;
      r.indicator_on = ind_lvl;
      r.courtesy_on = courtesy_act;
      r.auto_close_command = close_cmd;
      r.hmi_mask_phase = mask;
      r.preflash_ticks = pf_cnt;
      due_outputs.push_back(r);
    endfunction

    function void report(string what, int unsigned want, int unsigned got);
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t: mismatch %s: expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void compare(string what, int unsigned want, int unsigned got);
      if (want != got) report(what, want, got);
    endfunction

    // Match one delivered result against the oldest prediction
    function void check_result(res_t got);
      res_t want;
      if (due_outputs.size() == 0) begin
        report("result with none pending, packed value", 0, 32'(got));
        return;
      end
      want = due_outputs.pop_front();
      compare("lamp_on", 32'(want.lamp_on), 32'(got.lamp_on));
      compare("indicator_on", 32'(want.indicator_on), 32'(got.indicator_on));
      compare("courtesy_on", 32'(want.courtesy_on), 32'(got.courtesy_on));
      compare("auto_close_command", 32'(want.auto_close_command),
              32'(got.auto_close_command));
      compare("hmi_mask_phase", 32'(want.hmi_mask_phase), 32'(got.hmi_mask_phase));
      compare("preflash_ticks", 32'(want.preflash_ticks), 32'(got.preflash_ticks));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_lamp_enable = 1'b0;
  logic [1:0]            in_lamp_mode = '0;
  logic [1:0]            in_indicator_mode = '0;
  logic                  in_courtesy_start = 1'b0;
  logic                  in_auto_close_enable = 1'b0;
  logic                  in_mask_toggle_enable = 1'b0;
  logic                  in_preflash_count_enable = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_lamp_on;
  logic                  out_indicator_on;
  logic                  out_courtesy_on;
  logic                  out_auto_close_command;
  logic                  out_hmi_mask_phase;
  logic [7:0]            out_preflash_ticks;

  blinker_scoreboard sb;
  int unsigned cycle_count = 0;

  // Stimulus knobs shared between the driving processes
  bit          gaps_on = 1'b0;
  bit          stalls_on = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned pf_drop_pct = 3;
  int unsigned courtesy_pct = 5;
  int unsigned close_drop_pct = 3;
  lamp_mode_t  cur_lamp_mode = LAMP_RAPID;
  ind_mode_t   cur_ind_mode = IND_HOLD;
  int unsigned mode_run = 0;

  multi_mode_lamp_blinker_top DUT (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg_we                   (cfg_we),
    .cfg_index                (cfg_index),
    .cfg_wdata                (cfg_wdata),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_lamp_enable           (in_lamp_enable),
    .in_lamp_mode             (in_lamp_mode),
    .in_indicator_mode        (in_indicator_mode),
    .in_courtesy_start        (in_courtesy_start),
    .in_auto_close_enable     (in_auto_close_enable),
    .in_mask_toggle_enable    (in_mask_toggle_enable),
    .in_preflash_count_enable (in_preflash_count_enable),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_lamp_on              (out_lamp_on),
    .out_indicator_on         (out_indicator_on),
    .out_courtesy_on          (out_courtesy_on),
    .out_auto_close_command   (out_auto_close_command),
    .out_hmi_mask_phase       (out_hmi_mask_phase),
    .out_preflash_ticks       (out_preflash_ticks)
  );

  always #5 clk = ~clk;

  // Count cycles and give up at the limit
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Note each input transfer in the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_tick({in_lamp_enable, in_lamp_mode, in_indicator_mode, in_courtesy_start,
                    in_auto_close_enable, in_mask_toggle_enable, in_preflash_count_enable});
  end

  // Check each output transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_lamp_on, out_indicator_on, out_courtesy_on, out_auto_close_command,
                       out_hmi_mask_phase, out_preflash_ticks});
  end

  // Receiver: random stalls per result, one long hold-off on request
  initial begin : receiver
    int unsigned stall;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end
      stall = stalls_on ? $urandom_range(0, 6) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one tick, after an optional gap, and hold it until the transfer
  task automatic send_tick(input item_t t);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_lamp_enable <= t.lamp_enable;
    in_lamp_mode <= t.lamp_mode;
    in_indicator_mode <= t.indicator_mode;
    in_courtesy_start <= t.courtesy_start;
    in_auto_close_enable <= t.auto_close_enable;
    in_mask_toggle_enable <= t.mask_toggle_enable;
    in_preflash_count_enable <= t.preflash_count_enable;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_run(input item_t t, input int unsigned n);
    repeat (n) send_tick(t);
  endtask

  function automatic item_t make_tick(bit le, lamp_mode_t lm, ind_mode_t im,
                                      bit cs, bit ace, bit mte, bit pce);
    item_t t;
    t.lamp_enable = le;
    t.lamp_mode = lm;
    t.indicator_mode = im;
    t.courtesy_start = cs;
    t.auto_close_enable = ace;
    t.mask_toggle_enable = mte;
    t.preflash_count_enable = pce;
    return t;
  endfunction

  // Hold modes for runs of ticks so that patterns develop, with a little noise
  function automatic item_t draw_tick();
    item_t t;
    if (mode_run == 0) begin
      cur_lamp_mode = lamp_mode_t'($urandom_range(0, 3));
      cur_ind_mode = ind_mode_t'($urandom_range(0, 3));
      mode_run = $urandom_range(1, 40);
    end
    mode_run--;
    t.lamp_mode = ($urandom_range(0, 19) == 0) ? lamp_mode_t'($urandom_range(0, 3))
                                                : cur_lamp_mode;
    t.indicator_mode = ($urandom_range(0, 19) == 0) ? ind_mode_t'($urandom_range(0, 3))
                                                     : cur_ind_mode;
    t.lamp_enable = ($urandom_range(0, 9) != 0);
    t.courtesy_start = ($urandom_range(0, 99) < courtesy_pct);
    t.auto_close_enable = ($urandom_range(0, 99) >= close_drop_pct);
    t.mask_toggle_enable = 1'($urandom_range(0, 1));
    t.preflash_count_enable = ($urandom_range(0, 99) >= pf_drop_pct);
    return t;
  endfunction

  // Raise the write and record the preset after the clock edge; the caller drops cfg_we after the last write
  task automatic write_preset(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_preset(idx, val);
  endtask

  // Drop valid and wait until every predicted result has been delivered
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] ct, input logic [15:0] act,
                           input int unsigned n);
    wait_drain();
    write_preset(CFG_COURTESY_TIME, ct);
    write_preset(CFG_AUTO_CLOSE_TIME, act);
    write_preset(CFG_SPARE_LO, 16'($urandom));
    write_preset(CFG_SPARE_HI, 16'($urandom));
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
    repeat (n) send_tick(draw_tick());
  endtask

  initial begin : stimulus
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short presets so courtesy and auto close both flip during the directed part
    write_preset(CFG_COURTESY_TIME, 16'd2);
    write_preset(CFG_AUTO_CLOSE_TIME, 16'd3);
    write_preset(CFG_SPARE_LO, 16'hFFFF);
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed: field extremes, every mode, recovery cycle, low enables clearing
    send_run(make_tick(0, LAMP_RAPID, IND_HOLD, 0, 0, 0, 0), 1);
    send_run(make_tick(1, LAMP_HOLD, IND_DPULSE, 1, 1, 1, 1), 1);
    send_run(make_tick(1, LAMP_RAPID, IND_FAST, 0, 1, 1, 1), 2);
    send_run(make_tick(1, LAMP_SLOW, IND_SLOW, 0, 1, 0, 1), 4);
    send_run(make_tick(1, LAMP_RECOVERY, IND_DPULSE, 0, 1, 1, 1), 10);
    send_run(make_tick(0, LAMP_RECOVERY, IND_HOLD, 1, 0, 0, 0), 1);
    send_run(make_tick(1, LAMP_HOLD, IND_DPULSE, 0, 1, 0, 1), 3);

    // Random with full idling and one long receiver hold-off
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    hold_req = 1'b1;
    run_phase(16'd5, 16'd7, 300);

    // Zero presets at full rate; preflash never drops so it wraps
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    pf_drop_pct = 0;
    run_phase(16'd0, 16'd0, 300);

    // Maximum presets, sender gaps only
    gaps_on = 1'b1;
    pf_drop_pct = 5;
    run_phase(16'hFFFF, 16'hFFFF, 200);

    // Presets of one, receiver stalls only, frequent starts and drops
    gaps_on = 1'b0;
    stalls_on = 1'b1;
    courtesy_pct = 30;
    close_drop_pct = 20;
    run_phase(16'd1, 16'd1, 300);

    // Random small presets with everything idling
    gaps_on = 1'b1;
    courtesy_pct = 8;
    close_drop_pct = 5;
    run_phase(16'($urandom_range(1, 20)), 16'($urandom_range(1, 20)), 300);

    wait_drain();
    repeat (8) @(posedge clk);
    if (sb.err_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
